// ===== design/trilinear_grid_interpolator_macros.svh =====
// ---------------------------------------------------------------------------
// trilinear grid interpolator assertion macros
// shared property shapes for the interpolator's concurrent checks
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TGI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TGI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tgi_pkg.sv =====
// ---------------------------------------------------------------------------
// tgi_pkg
// types and constants shared by the trilinear grid interpolator
// ---------------------------------------------------------------------------
`default_nettype none

package tgi_pkg;

   // field widths
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 12;
   localparam int DIST_W      = 33;
   localparam int WEIGHT_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int STORE_DEPTH = 4096;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Z       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_PER_UNIT = 2'd3;

   // register reset values
   localparam logic [DATA_W-1:0] CELLS_PER_UNIT_RESET = 32'd983040;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_FETCH,
      ST_DONE
   } state_type;

   // single-port store access
   typedef struct packed {
      logic              write;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== design/tgi_req_if.sv =====
// ---------------------------------------------------------------------------
// tgi_req_if
// request channel: sample writes and point queries
// ---------------------------------------------------------------------------
`default_nettype none

interface tgi_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [tgi_pkg::ADDR_W-1:0]          sample_address;
   logic signed [tgi_pkg::DATA_W-1:0]   sample_value;
   logic signed [tgi_pkg::DATA_W-1:0]   point_x;
   logic signed [tgi_pkg::DATA_W-1:0]   point_y;
   logic signed [tgi_pkg::DATA_W-1:0]   point_z;

   modport source (
      output valid, command, sample_address, sample_value, point_x, point_y, point_z,
      input  ready
   );

   modport sink (
      input  valid, command, sample_address, sample_value, point_x, point_y, point_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/tgi_rsp_if.sv =====
// ---------------------------------------------------------------------------
// tgi_rsp_if
// response channel: interpolated value and outside flag
// ---------------------------------------------------------------------------
`default_nettype none

interface tgi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tgi_pkg::DATA_W-1:0]   field_value;
   logic                                outside;

   modport source (
      output valid, field_value, outside,
      input  ready
   );

   modport sink (
      input  valid, field_value, outside,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/tgi_csr_if.sv =====
// ---------------------------------------------------------------------------
// tgi_csr_if
// register write channel
// ---------------------------------------------------------------------------
`default_nettype none

interface tgi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tgi_pkg::CSR_INDEX_W-1:0]     index;
   logic [tgi_pkg::DATA_W-1:0]          data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/trilinear_grid_interpolator.sv =====
// ---------------------------------------------------------------------------
// trilinear_grid_interpolator
// trilinear interpolation over a cubic grid of Q16.16 samples
// ---------------------------------------------------------------------------
//   channel   dir  content
//   req_bus   in   command, sample_address, sample_value, point_x/y/z
//   rsp_bus   out  field_value, outside (one item per query)
//   csr_bus   in   index, data (origin_x/y/z, cells_per_unit)
//
// a sample write leaves the sequencer idle; the store is written as the item is taken
// a query inside the grid passes through accept, axis mapping on the shared
// 32x32 multiplier, eight store reads under seven blends, and result handoff;
// a query outside the grid skips the store and goes from mapping to handoff
// synchronous reset idles the sequencer and resets the configuration registers, not the store
// a waiting result blocks no new item; a finished query holds until it drains
// ---------------------------------------------------------------------------
`default_nettype none
`include "trilinear_grid_interpolator_macros.svh"

module trilinear_grid_interpolator #(
   parameter int GRID_POINTS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tgi_req_if.sink     req_bus,
   tgi_rsp_if.source   rsp_bus,
   tgi_csr_if.sink     csr_bus
);

   localparam int IDX_W  = $clog2(GRID_POINTS);
   localparam int FULL_W = (3 * IDX_W > tgi_pkg::ADDR_W) ? 3 * IDX_W : tgi_pkg::ADDR_W;
   localparam int STEP_W = 4;
   localparam logic [FULL_W-1:0] ROW_SIZE   = FULL_W'(GRID_POINTS);
   localparam logic [FULL_W-1:0] PLANE_SIZE = FULL_W'(GRID_POINTS * GRID_POINTS);

   // sequencer steps: mapping phase
   localparam logic [STEP_W-1:0] STEP_MAP_X = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MAP_Y = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MAP_Z = 4'd3;
   // sequencer steps: fetch and blend phase
   localparam logic [STEP_W-1:0] STEP_C0    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_B0    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_C2    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_B1    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_C4    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_B2    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_C6    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_B3    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_E0    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_E1    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_V     = 4'd12;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd14;

   // control state
   tgi_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [tgi_pkg::DATA_W-1:0] org_x_ff, org_y_ff, org_z_ff, cpu_ff;

   // query payload
   logic signed [tgi_pkg::DIST_W-1:0] dist_x_ff, dist_x_in;
   logic signed [tgi_pkg::DIST_W-1:0] dist_y_ff, dist_y_in;
   logic signed [tgi_pkg::DIST_W-1:0] dist_z_ff, dist_z_in;
   logic [IDX_W-1:0]  x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic [IDX_W-1:0]  y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic [IDX_W-1:0]  z_lo_ff, z_lo_in, z_hi_ff, z_hi_in;
   logic [tgi_pkg::WEIGHT_W-1:0] xw_ff, xw_in, yw_ff, yw_in, zw_ff, zw_in;
   logic              out_any_ff, out_any_in;
   logic signed [tgi_pkg::DATA_W-1:0] corner_ff, corner_in;
   logic signed [tgi_pkg::DATA_W-1:0] v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [tgi_pkg::DATA_W-1:0] e0_ff, e0_in;
   logic signed [tgi_pkg::DATA_W-1:0] final_ff, final_in;
   logic              final_out_ff, final_out_in;
   logic signed [tgi_pkg::DATA_W-1:0] rsp_field_ff, rsp_field_in;
   logic              rsp_outside_ff, rsp_outside_in;

   // datapath nets
   logic                              req_acc;
   logic                              csr_acc;
   tgi_pkg::mem_req_type              mem_req;
   logic [tgi_pkg::DATA_W-1:0]        rd_data;
   logic signed [tgi_pkg::DIST_W-1:0] loc_dist;
   logic [IDX_W-1:0]                  loc_lo, loc_hi;
   logic [tgi_pkg::WEIGHT_W-1:0]      loc_w;
   logic                              loc_outside;
   logic [IDX_W-1:0]                  cx, cy, cz;
   logic [FULL_W-1:0]                 corner_addr;
   logic signed [tgi_pkg::DATA_W-1:0] bl_a, bl_b, bl_out;
   logic [tgi_pkg::WEIGHT_W-1:0]      bl_w;

   // handshakes
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_acc       = csr_bus.valid && csr_bus.ready;
   assign req_bus.ready = (state_ff == tgi_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.field_value = rsp_field_ff;
   assign rsp_bus.outside     = rsp_outside_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         cpu_ff   <= tgi_pkg::CELLS_PER_UNIT_RESET;
      end else if (csr_acc) begin
         unique case (csr_bus.index)
            tgi_pkg::CSR_ORIGIN_X:       org_x_ff <= csr_bus.data;
            tgi_pkg::CSR_ORIGIN_Y:       org_y_ff <= csr_bus.data;
            tgi_pkg::CSR_ORIGIN_Z:       org_z_ff <= csr_bus.data;
            tgi_pkg::CSR_CELLS_PER_UNIT: cpu_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // axis mapping, one axis per cycle
   always_comb begin
      unique case (step_ff)
         4'd0:    loc_dist = dist_x_ff;
         4'd1:    loc_dist = dist_y_ff;
         default: loc_dist = dist_z_ff;
      endcase
   end

   tgi_locate #(
      .GRID_POINTS (GRID_POINTS)
   ) u_locate (
      .clock          (clock),
      .axis_dist      (loc_dist),
      .cells_per_unit (cpu_ff),
      .idx_lo         (loc_lo),
      .idx_hi         (loc_hi),
      .weight         (loc_w),
      .outside        (loc_outside)
   );

   // corner address: step bits pick lo or hi per axis
   assign cx = step_ff[0] ? x_hi_ff : x_lo_ff;
   assign cy = step_ff[1] ? y_hi_ff : y_lo_ff;
   assign cz = step_ff[2] ? z_hi_ff : z_lo_ff;
   assign corner_addr = FULL_W'(cz) * PLANE_SIZE + FULL_W'(cy) * ROW_SIZE + FULL_W'(cx);

   // store port: reads while fetching, writes on a write item
   always_comb begin
      mem_req.write = req_acc && (req_bus.command == tgi_pkg::CMD_WRITE);
      mem_req.wdata = req_bus.sample_value;
      if (state_ff == tgi_pkg::ST_FETCH) begin
         mem_req.addr = corner_addr[tgi_pkg::ADDR_W-1:0];
      end else begin
         mem_req.addr = req_bus.sample_address;
      end
   end

   tgi_grid_mem u_grid_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   // blend operand select per step
   always_comb begin
      unique case (step_ff)
         STEP_C6: begin
            bl_a = v0_ff;
            bl_b = v1_ff;
            bl_w = yw_ff;
         end
         STEP_E1: begin
            bl_a = v2_ff;
            bl_b = bl_out;
            bl_w = yw_ff;
         end
         STEP_V: begin
            bl_a = e0_ff;
            bl_b = bl_out;
            bl_w = zw_ff;
         end
         default: begin
            bl_a = corner_ff;
            bl_b = rd_data;
            bl_w = xw_ff;
         end
      endcase
   end

   tgi_blend u_blend (
      .clock  (clock),
      .a      (bl_a),
      .b      (bl_b),
      .weight (bl_w),
      .result (bl_out)
   );

   // sequencer next state and payload updates
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_field_in   = rsp_field_ff;
      rsp_outside_in = rsp_outside_ff;
      dist_x_in      = dist_x_ff;
      dist_y_in      = dist_y_ff;
      dist_z_in      = dist_z_ff;
      x_lo_in        = x_lo_ff;
      x_hi_in        = x_hi_ff;
      y_lo_in        = y_lo_ff;
      y_hi_in        = y_hi_ff;
      z_lo_in        = z_lo_ff;
      z_hi_in        = z_hi_ff;
      xw_in          = xw_ff;
      yw_in          = yw_ff;
      zw_in          = zw_ff;
      out_any_in     = out_any_ff;
      corner_in      = corner_ff;
      v0_in          = v0_ff;
      v1_in          = v1_ff;
      v2_in          = v2_ff;
      e0_in          = e0_ff;
      final_in       = final_ff;
      final_out_in   = final_out_ff;

      // output register drains
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tgi_pkg::ST_IDLE: begin
            if (req_acc && (req_bus.command == tgi_pkg::CMD_QUERY)) begin
               dist_x_in = {req_bus.point_x[tgi_pkg::DATA_W-1], req_bus.point_x}
                         - {org_x_ff[tgi_pkg::DATA_W-1], org_x_ff};
               dist_y_in = {req_bus.point_y[tgi_pkg::DATA_W-1], req_bus.point_y}
                         - {org_y_ff[tgi_pkg::DATA_W-1], org_y_ff};
               dist_z_in = {req_bus.point_z[tgi_pkg::DATA_W-1], req_bus.point_z}
                         - {org_z_ff[tgi_pkg::DATA_W-1], org_z_ff};
               state_in  = tgi_pkg::ST_MAP;
               step_in   = '0;
            end
         end

         tgi_pkg::ST_MAP: begin
            step_in = step_ff + STEP_W'(1);
            unique case (step_ff)
               STEP_MAP_X: begin
                  x_lo_in    = loc_lo;
                  x_hi_in    = loc_hi;
                  xw_in      = loc_w;
                  out_any_in = loc_outside;
               end
               STEP_MAP_Y: begin
                  y_lo_in    = loc_lo;
                  y_hi_in    = loc_hi;
                  yw_in      = loc_w;
                  out_any_in = out_any_ff || loc_outside;
               end
               STEP_MAP_Z: begin
                  z_lo_in = loc_lo;
                  z_hi_in = loc_hi;
                  zw_in   = loc_w;
                  if (out_any_ff || loc_outside) begin
                     final_in     = '0;
                     final_out_in = 1'b1;
                     state_in     = tgi_pkg::ST_DONE;
                  end else begin
                     state_in = tgi_pkg::ST_FETCH;
                     step_in  = '0;
                  end
               end
               default: ;
            endcase
         end

         tgi_pkg::ST_FETCH: begin
            step_in = step_ff + STEP_W'(1);
            unique case (step_ff)
               STEP_C0, STEP_C2, STEP_C4: corner_in = rd_data;
               STEP_C6: corner_in = rd_data;
               STEP_B1: v0_in = bl_out;
               STEP_B2: v1_in = bl_out;
               STEP_B3: v2_in = bl_out;
               STEP_E0: e0_in = bl_out;
               STEP_LAST: begin
                  final_in     = bl_out;
                  final_out_in = 1'b0;
                  state_in     = tgi_pkg::ST_DONE;
               end
               default: ;
            endcase
         end

         tgi_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_field_in   = final_ff;
               rsp_outside_in = final_out_ff;
               state_in       = tgi_pkg::ST_IDLE;
            end
         end

         default: state_in = tgi_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgi_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_field_ff   <= rsp_field_in;
      rsp_outside_ff <= rsp_outside_in;
      dist_x_ff      <= dist_x_in;
      dist_y_ff      <= dist_y_in;
      dist_z_ff      <= dist_z_in;
      x_lo_ff        <= x_lo_in;
      x_hi_ff        <= x_hi_in;
      y_lo_ff        <= y_lo_in;
      y_hi_ff        <= y_hi_in;
      z_lo_ff        <= z_lo_in;
      z_hi_ff        <= z_hi_in;
      xw_ff          <= xw_in;
      yw_ff          <= yw_in;
      zw_ff          <= zw_in;
      out_any_ff     <= out_any_in;
      corner_ff      <= corner_in;
      v0_ff          <= v0_in;
      v1_ff          <= v1_in;
      v2_ff          <= v2_in;
      e0_ff          <= e0_in;
      final_ff       <= final_in;
      final_out_ff   <= final_out_in;
   end

   // checks
   `TGI_ASSERT_NEXT(a_query_starts_map, clock, reset,
      req_acc && (req_bus.command == tgi_pkg::CMD_QUERY),
      (state_ff == tgi_pkg::ST_MAP) && (step_ff == '0),
      "query item did not start axis mapping")
   `TGI_ASSERT_NEXT(a_write_stays_idle, clock, reset,
      req_acc && (req_bus.command == tgi_pkg::CMD_WRITE),
      state_ff == tgi_pkg::ST_IDLE,
      "write item left the idle state")
   `TGI_ASSERT_IMPLIES(a_outside_is_zero, clock, reset,
      rsp_valid_ff && rsp_outside_ff,
      rsp_field_ff == '0,
      "outside item carries a nonzero value")
   `TGI_ASSERT_IMPLIES(a_fetch_step_range, clock, reset,
      state_ff == tgi_pkg::ST_FETCH,
      step_ff <= STEP_LAST,
      "fetch step ran past the last blend")

endmodule

`default_nettype wire

// ===== design/tgi_grid_mem.sv =====
// ---------------------------------------------------------------------------
// tgi_grid_mem
// single-port grid sample store, read-first, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module tgi_grid_mem (
   input  wire logic                        clock,
   input  wire tgi_pkg::mem_req_type        req,
   output logic [tgi_pkg::DATA_W-1:0]       rd_data
);

   logic [tgi_pkg::DATA_W-1:0] store [tgi_pkg::STORE_DEPTH];
   logic [tgi_pkg::DATA_W-1:0] rd_data_ff;

   // write and registered read on the one port
   always_ff @(posedge clock) begin
      if (req.write) begin
         store[req.addr] <= req.wdata;
      end
      rd_data_ff <= store[req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/tgi_locate.sv =====
// ---------------------------------------------------------------------------
// tgi_locate
// maps one axis distance to cell indexes and a blend weight
// ---------------------------------------------------------------------------
`default_nettype none

module tgi_locate #(
   parameter int GRID_POINTS = 16
) (
   input  wire logic                                clock,
   input  wire logic signed [tgi_pkg::DIST_W-1:0]   axis_dist,
   input  wire logic [tgi_pkg::DATA_W-1:0]          cells_per_unit,
   output logic [$clog2(GRID_POINTS)-1:0]           idx_lo,
   output logic [$clog2(GRID_POINTS)-1:0]           idx_hi,
   output logic [tgi_pkg::WEIGHT_W-1:0]             weight,
   output logic                                     outside
);

   localparam int IDX_W  = $clog2(GRID_POINTS);
   localparam int PROD_W = 2 * tgi_pkg::DATA_W;
   localparam int HI_W   = tgi_pkg::DATA_W + 1;

   logic [PROD_W-1:0]          prod_in;
   logic [PROD_W-1:0]          prod_ff;
   logic                       neg_ff;
   logic [tgi_pkg::DATA_W-1:0] cell_int;
   logic                       has_frac;
   logic [HI_W-1:0]            cell_hi;

   // grid coordinate with 32 fraction bits
   assign prod_in = axis_dist[tgi_pkg::DATA_W-1:0] * cells_per_unit;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= axis_dist[tgi_pkg::DIST_W-1];
   end

   // split into integer cell and fraction
   assign cell_int = prod_ff[PROD_W-1:tgi_pkg::DATA_W];
   assign has_frac = |prod_ff[tgi_pkg::DATA_W-1:0];
   assign cell_hi  = {1'b0, cell_int} + HI_W'(has_frac);

   // negative distance only counts when the scale is nonzero
   assign outside = (neg_ff && (cells_per_unit != '0)) || (cell_hi >= HI_W'(GRID_POINTS));
   assign idx_lo  = cell_int[IDX_W-1:0];
   assign idx_hi  = cell_hi[IDX_W-1:0];
   assign weight  = prod_ff[tgi_pkg::DATA_W-1:tgi_pkg::DATA_W-tgi_pkg::WEIGHT_W];

endmodule

`default_nettype wire

// ===== design/tgi_blend.sv =====
// ---------------------------------------------------------------------------
// tgi_blend
// two-stage linear blend a + round((b - a) * w / 2^16), saturated
// ---------------------------------------------------------------------------
`default_nettype none

module tgi_blend (
   input  wire logic                                clock,
   input  wire logic signed [tgi_pkg::DATA_W-1:0]   a,
   input  wire logic signed [tgi_pkg::DATA_W-1:0]   b,
   input  wire logic [tgi_pkg::WEIGHT_W-1:0]        weight,
   output logic signed [tgi_pkg::DATA_W-1:0]        result
);

   localparam int DIFF_W = tgi_pkg::DATA_W + 1;
   localparam int PROD_W = DIFF_W + tgi_pkg::WEIGHT_W + 1;
   localparam int SH_W   = PROD_W - tgi_pkg::WEIGHT_W;
   localparam int SUM_W  = SH_W + 1;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (tgi_pkg::WEIGHT_W - 1);
   localparam logic signed [tgi_pkg::DATA_W-1:0] MAX_VAL = {1'b0, {(tgi_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [tgi_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(tgi_pkg::DATA_W-1){1'b0}}};

   logic signed [DIFF_W-1:0]          diff;
   logic signed [PROD_W-1:0]          prod_in;
   logic signed [PROD_W-1:0]          prod_ff;
   logic signed [tgi_pkg::DATA_W-1:0] base_ff;
   logic signed [PROD_W-1:0]          rounded;
   logic signed [SH_W-1:0]            step;
   logic signed [SUM_W-1:0]           sum;
   logic signed [tgi_pkg::DATA_W-1:0] result_in;
   logic signed [tgi_pkg::DATA_W-1:0] result_ff;

   // stage one: weighted difference
   assign diff    = {b[tgi_pkg::DATA_W-1], b} - {a[tgi_pkg::DATA_W-1], a};
   assign prod_in = diff * $signed({1'b0, weight});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= a;
   end

   // stage two: round half up, add base, clamp
   assign rounded = prod_ff + HALF;
   assign step    = rounded[PROD_W-1:tgi_pkg::WEIGHT_W];
   assign sum     = {{(SUM_W-tgi_pkg::DATA_W){base_ff[tgi_pkg::DATA_W-1]}}, base_ff}
                  + {step[SH_W-1], step};

   always_comb begin
      priority if (sum > SUM_W'(MAX_VAL)) begin
         result_in = MAX_VAL;
      end else if (sum < SUM_W'(MIN_VAL)) begin
         result_in = MIN_VAL;
      end else begin
         result_in = sum[tgi_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trilinear grid interpolator. A queue of sample
// writes and point queries feeds a handshake driver. A monitor updates a
// local copy of the grid store and registers, predicts each query's blend
// and compares every returned item field by field. The run steps through
// several origin and cell-scale settings, including zero and full scale.
// ---------------------------------------------------------------------------

module tb_top;
   import tgi_pkg::*;

   localparam int GRID_N         = 16;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 105;

   typedef struct {
      logic                     command;
      logic [ADDR_W-1:0]        address;
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic signed [DATA_W-1:0] pz;
   } grid_op_t;

   typedef struct {
      logic signed [DATA_W-1:0] field_value;
      logic                     outside;
   } probe_result_t;

   logic clock;
   logic reset;

   tgi_req_if req_bus ();
   tgi_rsp_if rsp_bus ();
   tgi_csr_if csr_bus ();

   trilinear_grid_interpolator #(.GRID_POINTS(GRID_N)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // pending stimulus and outstanding predictions
   grid_op_t      pending_ops[$];
   probe_result_t expected_results[$];

   // local copy of the store and the registers, updated on accepted items
   logic signed [DATA_W-1:0] grid_copy [STORE_DEPTH];
   logic signed [DATA_W-1:0] cfg_origin_x, cfg_origin_y, cfg_origin_z;
   logic [DATA_W-1:0]        cfg_cells;

   // settings and written entries as planned by the stimulus generator
   logic signed [DATA_W-1:0] plan_origin_x, plan_origin_y, plan_origin_z;
   logic [DATA_W-1:0]        plan_cells;
   bit                       sample_known [STORE_DEPTH];

   int  n_queued, n_accepted, n_writes, n_queries, n_inside, n_outside;
   int  n_settings, mismatches, idle_cycles;
   int  req_gap, rsp_gap;
   bit  req_taken;
   bit  calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // map one coordinate onto the grid; returns 0 when outside
   function automatic bit axis_map(input logic signed [DATA_W-1:0] point,
                                   input logic signed [DATA_W-1:0] origin,
                                   input logic [DATA_W-1:0] cells,
                                   output int lo, output int hi,
                                   output logic [WEIGHT_W-1:0] weight);
      longint     offset;
      logic [63:0] coord;
      longint     whole;
      int         step;
      lo = 0;
      hi = 0;
      weight = '0;
      if (cells == '0) return 1'b1;
      offset = longint'(point) - longint'(origin);
      if (offset < 0) return 1'b0;
      coord = 64'(offset) * {32'd0, cells};
      whole = longint'({32'd0, coord[63:32]});
      step = (coord[31:0] != 32'd0) ? 1 : 0;
      if (whole + step >= GRID_N) return 1'b0;
      lo = int'(whole);
      hi = lo + step;
      weight = coord[31:16];
      return 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] grid_index(input int x, input int y, input int z);
      return ADDR_W'((z * GRID_N * GRID_N + y * GRID_N + x) & (STORE_DEPTH - 1));
   endfunction

   // the eight cell corners and the three weights of a query point
   function automatic bit probe_corners(input grid_op_t op,
                                        input logic signed [DATA_W-1:0] ox,
                                        input logic signed [DATA_W-1:0] oy,
                                        input logic signed [DATA_W-1:0] oz,
                                        input logic [DATA_W-1:0] cells,
                                        output logic [7:0][ADDR_W-1:0] corner,
                                        output logic [2:0][WEIGHT_W-1:0] wt);
      int xl, xh, yl, yh, zl, zh;
      bit in_x, in_y, in_z;
      corner = '0;
      in_x = axis_map(op.px, ox, cells, xl, xh, wt[0]);
      in_y = axis_map(op.py, oy, cells, yl, yh, wt[1]);
      in_z = axis_map(op.pz, oz, cells, zl, zh, wt[2]);
      if (!(in_x && in_y && in_z)) return 1'b0;
      for (int i = 0; i < 8; i++)
         corner[i] = grid_index(i[0] ? xh : xl, i[1] ? yh : yl, i[2] ? zh : zl);
      return 1'b1;
   endfunction

   // one linear blend, rounded to nearest with ties upward, saturated
   function automatic logic signed [DATA_W-1:0] lerp(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b,
                                                     input logic [WEIGHT_W-1:0] w);
      longint acc;
      acc = longint'(a) * (longint'(65536) - longint'(w)) + longint'(b) * longint'(w)
            + longint'(32768);
      acc = acc >>> 16;
      if (acc > longint'(32'sh7FFFFFFF)) acc = longint'(32'sh7FFFFFFF);
      if (acc < -longint'(32'sh7FFFFFFF) - 1) acc = -longint'(32'sh7FFFFFFF) - 1;
      return acc[DATA_W-1:0];
   endfunction

   // expected result of a query against the current store and registers
   function automatic probe_result_t predict_probe(input grid_op_t op);
      probe_result_t res;
      logic [7:0][ADDR_W-1:0]   corner;
      logic [2:0][WEIGHT_W-1:0] wt;
      logic signed [DATA_W-1:0] c00, c10, c01, c11, e0, e1;
      res.field_value = '0;
      res.outside = 1'b1;
      if (!probe_corners(op, cfg_origin_x, cfg_origin_y, cfg_origin_z, cfg_cells,
                         corner, wt))
         return res;
      c00 = lerp(grid_copy[corner[0]], grid_copy[corner[1]], wt[0]);
      c10 = lerp(grid_copy[corner[2]], grid_copy[corner[3]], wt[0]);
      c01 = lerp(grid_copy[corner[4]], grid_copy[corner[5]], wt[0]);
      c11 = lerp(grid_copy[corner[6]], grid_copy[corner[7]], wt[0]);
      e0 = lerp(c00, c10, wt[1]);
      e1 = lerp(c01, c11, wt[1]);
      res.field_value = lerp(e0, e1, wt[2]);
      res.outside = 1'b0;
      return res;
   endfunction

   // sample values lean toward the extremes
   function automatic logic signed [DATA_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_origin();
      return $signed($urandom) >>> 1;
   endfunction

   // a coordinate inside the grid span, sometimes snapped onto a grid plane
   function automatic logic signed [DATA_W-1:0] in_grid_point(
         input logic signed [DATA_W-1:0] origin);
      logic [63:0] span, offset;
      int tz;
      if (plan_cells == '0) return $urandom;
      span = (64'd15 << 32) / plan_cells;
      if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
      offset = {$urandom, $urandom} % (span + 64'd1);
      if ($urandom_range(0, 3) == 0) begin
         for (tz = 0; tz < 32 && !plan_cells[tz]; tz++) ;
         offset = (offset >> (32 - tz)) << (32 - tz);
      end
      return origin + offset[31:0];
   endfunction

   // a coordinate just past the far plane or just below the origin
   function automatic logic signed [DATA_W-1:0] edge_point(
         input logic signed [DATA_W-1:0] origin);
      logic [63:0] span;
      if (plan_cells == '0 || $urandom_range(0, 1) == 0)
         return origin - $urandom_range(1, 1000);
      span = (64'd15 << 32) / plan_cells;
      return origin + span[31:0] + $urandom_range(1, 3);
   endfunction

   task automatic enqueue(input grid_op_t op);
      pending_ops.push_back(op);
      n_queued++;
   endtask

   task automatic add_write(input logic [ADDR_W-1:0] addr, input logic signed [DATA_W-1:0] val);
      grid_op_t op;
      op.command = CMD_WRITE;
      op.address = addr;
      op.sample  = val;
      op.px = $urandom;
      op.py = $urandom;
      op.pz = $urandom;
      sample_known[addr] = 1'b1;
      n_writes++;
      enqueue(op);
   endtask

   // query a point, first writing any corner that has never been stored
   task automatic add_query(input logic signed [DATA_W-1:0] px,
                            input logic signed [DATA_W-1:0] py,
                            input logic signed [DATA_W-1:0] pz);
      grid_op_t op;
      logic [7:0][ADDR_W-1:0]   corner;
      logic [2:0][WEIGHT_W-1:0] wt;
      op.command = CMD_QUERY;
      op.address = $urandom_range(0, STORE_DEPTH - 1);
      op.sample  = $urandom;
      op.px = px;
      op.py = py;
      op.pz = pz;
      if (probe_corners(op, plan_origin_x, plan_origin_y, plan_origin_z, plan_cells,
                        corner, wt))
         for (int i = 0; i < 8; i++)
            if (!sample_known[corner[i]]) add_write(corner[i], rand_sample());
      n_queries++;
      enqueue(op);
   endtask

   // wait until every item is taken and every result is back
   task automatic drain();
      while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic signed [DATA_W-1:0] ox,
                             input logic signed [DATA_W-1:0] oy,
                             input logic signed [DATA_W-1:0] oz,
                             input logic [DATA_W-1:0] cells);
      drain();
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_CELLS_PER_UNIT, cells);
      plan_origin_x = ox;
      plan_origin_y = oy;
      plan_origin_z = oz;
      plan_cells    = cells;
      n_settings++;
   endtask

   // mostly well-formed queries, with stray writes, noise and edge points
   task automatic random_phase(input int n_items);
      int start;
      logic signed [DATA_W-1:0] px, py, pz;
      start = n_queued;
      while (n_queued - start < n_items) begin
         px = in_grid_point(plan_origin_x);
         py = in_grid_point(plan_origin_y);
         pz = in_grid_point(plan_origin_z);
         case ($urandom_range(0, 15))
            0: add_write($urandom_range(0, STORE_DEPTH - 1), rand_sample());
            1: add_query($urandom, $urandom, $urandom);
            2: begin
               case ($urandom_range(0, 2))
                  0: px = edge_point(plan_origin_x);
                  1: py = edge_point(plan_origin_y);
                  default: pz = edge_point(plan_origin_z);
               endcase
               add_query(px, py, pz);
            end
            default: add_query(px, py, pz);
         endcase
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_bus.valid && !req_taken) begin
            // hold the item until it is taken
         end else if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_ops.size() > 0) begin
            grid_op_t op;
            op = pending_ops.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.command        <= op.command;
            req_bus.sample_address <= op.address;
            req_bus.sample_value   <= op.sample;
            req_bus.point_x        <= op.px;
            req_bus.point_y        <= op.py;
            req_bus.point_z        <= op.pz;
            if (!calm && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 8);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap <= $urandom_range(0, 7);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor, predictor update, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         cfg_origin_x = '0;
         cfg_origin_y = '0;
         cfg_origin_z = '0;
         cfg_cells    = CELLS_PER_UNIT_RESET;
         req_taken    = 1'b0;
         idle_cycles  = 0;
      end else begin
         bit busy;
         probe_result_t exp_res;
         busy = 1'b0;

         // returned item against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            busy = 1'b1;
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual value %h outside %b",
                        $time, rsp_bus.field_value, rsp_bus.outside);
               mismatches++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_bus.field_value !== exp_res.field_value) begin
                  $display("%0t field_value mismatch: expected %h actual %h",
                           $time, exp_res.field_value, rsp_bus.field_value);
                  mismatches++;
               end
               if (rsp_bus.outside !== exp_res.outside) begin
                  $display("%0t outside mismatch: expected %b actual %b",
                           $time, exp_res.outside, rsp_bus.outside);
                  mismatches++;
               end
               if (exp_res.outside) n_outside++;
               else n_inside++;
            end
         end

         // accepted item
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            grid_op_t op;
            busy = 1'b1;
            n_accepted++;
            op.command = req_bus.command;
            op.address = req_bus.sample_address;
            op.sample  = req_bus.sample_value;
            op.px = req_bus.point_x;
            op.py = req_bus.point_y;
            op.pz = req_bus.point_z;
            if (op.command == CMD_WRITE) grid_copy[op.address] = op.sample;
            else expected_results.push_back(predict_probe(op));
         end

         // register write
         if (csr_bus.valid && csr_bus.ready) begin
            busy = 1'b1;
            case (csr_bus.index)
               CSR_ORIGIN_X:       cfg_origin_x = csr_bus.data;
               CSR_ORIGIN_Y:       cfg_origin_y = csr_bus.data;
               CSR_ORIGIN_Z:       cfg_origin_z = csr_bus.data;
               CSR_CELLS_PER_UNIT: cfg_cells    = csr_bus.data;
               default: ;
            endcase
         end

         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_WRITE;
      req_bus.sample_address = '0;
      req_bus.sample_value = '0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ORIGIN_X;
      csr_bus.data = '0;
      plan_origin_x = '0;
      plan_origin_y = '0;
      plan_origin_z = '0;
      plan_cells = CELLS_PER_UNIT_RESET;
      calm = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: grid spans one unit, extremes at the two far corners
      add_write(grid_index(0, 0, 0), 32'sh7FFFFFFF);
      add_write(grid_index(GRID_N - 1, GRID_N - 1, GRID_N - 1), 32'sh80000000);
      add_query(0, 0, 0);
      add_query(32'sh00010000, 32'sh00010000, 32'sh00010000);
      add_query(32'sh00010001, 0, 0);
      add_query(0, -1, 0);
      add_query(0, 0, 32'sh80000000);
      add_query(32'sh7FFFFFFF, 0, 0);
      add_query(2185, 3000, 4000);

      // zero scale: every point lands on the first sample
      set_config(32'sh80000000, 32'sh7FFFFFFF, rand_origin(), 32'd0);
      add_query($urandom, $urandom, $urandom);
      add_query(32'sh80000000, 32'sh7FFFFFFF, 0);
      add_write(grid_index(0, 0, 0), rand_sample());
      add_query($urandom, $urandom, $urandom);

      // smallest scale: fractions below weight resolution and near-half weight
      set_config(0, 0, 0, 32'd1);
      add_query(32'sh0000FFFF, 32'sh7FFFFFFF, 1);

      // largest scale
      set_config(0, 0, 0, 32'hFFFFFFFF);
      add_query(0, 0, 0);
      add_query(16, 0, 0);

      set_config(rand_origin(), rand_origin(), rand_origin(), 32'h0001_0000);
      random_phase(PHASE_ITEMS);
      set_config(32'sh80000000, rand_origin(), rand_origin(), CELLS_PER_UNIT_RESET);
      random_phase(PHASE_ITEMS);
      set_config(rand_origin(), rand_origin(), rand_origin(),
                 $urandom_range(1, 32'hFFFFFFFF));
      random_phase(PHASE_ITEMS);
      set_config(-rand_origin(), rand_origin(), -rand_origin(), 32'h0008_0000);
      random_phase(PHASE_ITEMS);

      // closing stretch at full rate
      set_config(rand_origin(), rand_origin(), rand_origin(), 32'h0003_0000);
      calm = 1'b1;
      random_phase(PHASE_ITEMS);
      drain();

      $display("covered %0d sample writes and %0d queries (%0d inside, %0d outside)",
               n_writes, n_queries, n_inside, n_outside);
      $display("across %0d register settings, %0d field mismatches", n_settings + 1,
               mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/tgi_pkg.sv
design/tgi_req_if.sv
design/tgi_rsp_if.sv
design/tgi_csr_if.sv
design/tgi_grid_mem.sv
design/tgi_locate.sv
design/tgi_blend.sv
design/trilinear_grid_interpolator.sv
bench/tb_top.sv
